@@ hdl/vertex_project_to_window_assert.svh @@
// Assertion macros used by the checker file of the vertex projection block.
`ifndef VERTEX_PROJECT_TO_WINDOW_ASSERT_SVH
`define VERTEX_PROJECT_TO_WINDOW_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define VPW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define VPW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/vpw_pkg.sv @@
// Shared types and constants of the vertex projection block.
`default_nettype none
package vpw_pkg;

   // control that travels with each word through the transform stages
   typedef struct packed {
      logic       valid;
      logic       proj;
      logic [4:0] idx;
   } vpw_ctl_type;

   // control that travels alongside the dividers
   typedef struct packed {
      logic valid;
      logic ok;
   } vpw_tag_type;

   // request kinds
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_PROJECT = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_VP_X = 2'd0;
   localparam logic [1:0] CSR_VP_Y = 2'd1;
   localparam logic [1:0] CSR_VP_W = 2'd2;
   localparam logic [1:0] CSR_VP_H = 2'd3;

   localparam int IDX_W     = 5;
   localparam int VP_POS_W  = 16;
   localparam int VP_SIZE_W = 15;

endpackage
`default_nettype wire

@@ hdl/vpw_xform.sv @@
// One 4x4 matrix times vector transform: products, sum, shift and saturate.
`default_nettype none
module vpw_xform
   import vpw_pkg::*;
#(
   parameter int   DATA_WIDTH = 32,
   parameter int   FRAC_BITS  = 16,
   parameter logic MAT_SEL    = 1'b0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire vpw_ctl_type                  in_ctl,
   input  wire logic signed [DATA_WIDTH-1:0] in_coef,
   input  wire logic signed [DATA_WIDTH-1:0] in_vec [4],
   output vpw_ctl_type                       out_ctl,
   output logic signed [DATA_WIDTH-1:0]      out_coef,
   output logic signed [DATA_WIDTH-1:0]      out_vec [4]
);
   localparam int DW = DATA_WIDTH;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 2;

   logic signed [DW-1:0] mat_ff [16];

   logic signed [PW-1:0] prod_in [4][4];
   logic signed [PW-1:0] prod_ff [4][4];
   logic signed [SW-1:0] sum_in  [4];
   logic signed [SW-1:0] sum_ff  [4];
   logic signed [DW-1:0] res_in  [4];
   logic signed [DW-1:0] res_ff  [4];

   vpw_ctl_type          ctl_a_ff, ctl_b_ff, ctl_c_ff;
   logic signed [DW-1:0] coef_a_ff, coef_b_ff, coef_c_ff;

   // arithmetic shift by the fraction bits, then saturate
   function automatic logic [DW-1:0] narrow(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] s;
      s = v >>> FRAC_BITS;
      if ((&s[SW-1:DW-1]) || !(|s[SW-1:DW-1])) begin
         narrow = s[DW-1:0];
      end else if (s[SW-1]) begin
         narrow = {1'b1, {(DW-1){1'b0}}};
      end else begin
         narrow = {1'b0, {(DW-1){1'b1}}};
      end
   endfunction

   // coefficient store, written when a load word whose index selects this matrix passes this stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (en && in_ctl.valid && (in_ctl.proj == REQ_LOAD) &&
                   (in_ctl.idx[4] == MAT_SEL)) begin
         mat_ff[in_ctl.idx[3:0]] <= in_coef;
      end
   end

   // products, row sums and narrowing
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[r][c] = PW'(mat_ff[c*4+r]) * PW'(in_vec[c]);
         end
         sum_in[r] = SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) +
                     SW'(prod_ff[r][2]) + SW'(prod_ff[r][3]);
         res_in[r] = narrow(sum_ff[r]);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else if (en) begin
         ctl_a_ff <= in_ctl;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         coef_a_ff <= in_coef;
         coef_b_ff <= coef_a_ff;
         coef_c_ff <= coef_b_ff;
         prod_ff   <= prod_in;
         sum_ff    <= sum_in;
         res_ff    <= res_in;
      end
   end

   assign out_ctl  = ctl_c_ff;
   assign out_coef = coef_c_ff;
   assign out_vec  = res_ff;

endmodule
`default_nettype wire

@@ hdl/vpw_div.sv @@
// Pipelined fixed-point divider, one quotient bit per stage, saturated result.
`default_nettype none
module vpw_div
   import vpw_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic signed [DATA_WIDTH-1:0] num,
   input  wire logic signed [DATA_WIDTH-1:0] den,
   output logic signed [DATA_WIDTH-1:0]      quo
);
   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;

   logic [DW-1:0] mag;
   logic [DW-1:0] top;

   logic [DW-1:0] rem_ff [DW];
   logic [DW-1:0] low_ff [DW];
   logic [DW-1:0] den_ff [DW];
   logic [DW-1:0] q_ff   [DW+1];
   logic          neg_ff [DW+1];
   logic          ovf_ff [DW+1];

   logic [DW:0]   trial  [DW];
   logic [DW:0]   diff   [DW];
   logic          qbit   [DW];
   logic [DW-1:0] rem_in [DW];

   logic [DW-1:0] q_fin;
   logic [DW-1:0] res_in;
   logic [DW-1:0] res_ff;

   // magnitude and the part of the numerator above the quotient window
   always_comb begin
      mag = num[DW-1] ? DW'(-num) : DW'(num);
      top = DW'(mag[DW-1 -: FB]);
   end

   // restoring steps
   always_comb begin
      for (int j = 0; j < DW; j++) begin
         trial[j] = {rem_ff[j], low_ff[j][DW-1]};
         diff[j]  = trial[j] - {1'b0, den_ff[j]};
         qbit[j]  = (trial[j] >= {1'b0, den_ff[j]});
         rem_in[j] = qbit[j] ? diff[j][DW-1:0] : trial[j][DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= top;
         low_ff[0] <= {mag[DW-FB-1:0], {FB{1'b0}}};
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[DW-1];
         ovf_ff[0] <= (top >= den);
         for (int j = 0; j < DW - 1; j++) begin
            rem_ff[j+1] <= rem_in[j];
            low_ff[j+1] <= low_ff[j] << 1;
            den_ff[j+1] <= den_ff[j];
         end
         for (int j = 0; j < DW; j++) begin
            q_ff[j+1]   <= {q_ff[j][DW-2:0], qbit[j]};
            neg_ff[j+1] <= neg_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
         end
         res_ff <= res_in;
      end
   end

   // sign and saturation
   always_comb begin
      q_fin = q_ff[DW];
      if (ovf_ff[DW]) begin
         res_in = neg_ff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else if (neg_ff[DW]) begin
         if (q_fin[DW-1] && (|q_fin[DW-2:0])) begin
            res_in = {1'b1, {(DW-1){1'b0}}};
         end else begin
            res_in = -q_fin;
         end
      end else if (q_fin[DW-1]) begin
         res_in = {1'b0, {(DW-1){1'b1}}};
      end else begin
         res_in = q_fin;
      end
   end

   assign quo = res_ff;

endmodule
`default_nettype wire

@@ hdl/vpw_window.sv @@
// Viewport and depth mapping of normalized coordinates, two register stages.
`default_nettype none
module vpw_window
   import vpw_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire vpw_tag_type                  in_tag,
   input  wire logic signed [DATA_WIDTH-1:0] nx,
   input  wire logic signed [DATA_WIDTH-1:0] ny,
   input  wire logic signed [DATA_WIDTH-1:0] nz,
   input  wire logic signed [VP_POS_W-1:0]   vp_x,
   input  wire logic signed [VP_POS_W-1:0]   vp_y,
   input  wire logic [VP_SIZE_W-1:0]         vp_w,
   input  wire logic [VP_SIZE_W-1:0]         vp_h,
   output logic                              out_valid,
   output logic                              out_ok,
   output logic signed [DATA_WIDTH-1:0]      win_x,
   output logic signed [DATA_WIDTH-1:0]      win_y,
   output logic signed [DATA_WIDTH-1:0]      win_z
);
   localparam int DW  = DATA_WIDTH;
   localparam int AW  = DW + 1;
   localparam int MW  = AW + VP_POS_W;
   localparam int SW2 = DW + FRAC_BITS + 18;
   localparam logic signed [AW-1:0] ONE_Q = AW'(64'd1 << FRAC_BITS);

   logic signed [AW-1:0]  ax, ay, az;
   logic signed [MW-1:0]  px_in, py_in;
   logic signed [MW-1:0]  px_ff, py_ff;
   logic signed [DW-1:0]  zh_in, zh_ff;
   vpw_tag_type           tag_ff;
   logic signed [SW2-1:0] sx, sy;

   logic                  valid_ff, ok_ff;
   logic signed [DW-1:0]  wx_ff, wy_ff, wz_ff;

   function automatic logic [DW-1:0] sat(input logic signed [SW2-1:0] v);
      if ((&v[SW2-1:DW-1]) || !(|v[SW2-1:DW-1])) begin
         sat = v[DW-1:0];
      end else if (v[SW2-1]) begin
         sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
         sat = {1'b0, {(DW-1){1'b1}}};
      end
   endfunction

   // stage 1: (1 + n) times size, depth halved
   always_comb begin
      ax    = AW'(nx) + ONE_Q;
      ay    = AW'(ny) + ONE_Q;
      az    = AW'(nz) + ONE_Q;
      px_in = MW'(ax) * MW'($signed({1'b0, vp_w}));
      py_in = MW'(ay) * MW'($signed({1'b0, vp_h}));
      zh_in = DW'(az >>> 1);
   end

   // stage 2: origin plus floor half, saturated
   always_comb begin
      sx = (SW2'(vp_x) <<< FRAC_BITS) + SW2'(px_ff >>> 1);
      sy = (SW2'(vp_y) <<< FRAC_BITS) + SW2'(py_ff >>> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         valid_ff <= 1'b0;
      end else if (en) begin
         tag_ff   <= in_tag;
         valid_ff <= tag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         zh_ff <= zh_in;
         ok_ff <= tag_ff.ok;
         wx_ff <= tag_ff.ok ? sat(sx) : '0;
         wy_ff <= tag_ff.ok ? sat(sy) : '0;
         wz_ff <= tag_ff.ok ? zh_ff : '0;
      end
   end

   assign out_valid = valid_ff;
   assign out_ok    = ok_ff;
   assign win_x     = wx_ff;
   assign win_y     = wy_ff;
   assign win_z     = wz_ff;

endmodule
`default_nettype wire

@@ hdl/vertex_project_to_window.sv @@
// Throughput: one word per cycle while no result waits for rsp_tready;
// the divider retires one quotient bit per stage.
// The whole pipeline advances together and holds while a result waits for rsp_tready.
// Load words give no result; each project word gives exactly one.
// Reset (synchronous, high) clears valid bits, both matrices and the viewport registers.
`default_nettype none
module vertex_project_to_window
   import vpw_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32,
   localparam int REQ_W = ((IDX_W + 4 * DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // coef_index, coef_value, obj_x, obj_y, obj_z
   input  wire logic [REQ_W-1:0]      req_tdata,
   // req_type
   input  wire logic [0:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // win_x, win_y, win_z
   output logic [RSP_W-1:0]           rsp_tdata,
   // accepted
   output logic [0:0]                 rsp_tuser,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_addr,
   input  wire logic [VP_POS_W-1:0]   csr_wdata
);
   localparam int DW      = DATA_WIDTH;
   localparam int DIV_LAT = DW + 2;
   localparam int TH_RAW  = ((1 << FRAC_BITS) + 5000) / 10000;
   localparam int TH      = (TH_RAW < 1) ? 1 : TH_RAW;
   localparam logic signed [DW-1:0] W_MIN_Q = DW'(TH);
   localparam logic signed [DW-1:0] ONE_Q   = DW'(64'd1 << FRAC_BITS);

   logic                  en;
   logic                  req_acc;

   logic signed [VP_POS_W-1:0] vp_x_ff, vp_y_ff;
   logic [VP_SIZE_W-1:0]       vp_w_ff, vp_h_ff;

   vpw_ctl_type           ctl0_in, ctl0_ff, ctl1, ctl2;
   logic signed [DW-1:0]  coef0_ff, coef1;
   logic signed [DW-1:0]  vec0_ff [4];
   logic signed [DW-1:0]  eye [4];
   logic signed [DW-1:0]  clip [4];

   vpw_tag_type           tag_in;
   vpw_tag_type           tag_ff [DIV_LAT];
   logic signed [DW-1:0]  nx, ny, nz;

   logic                  out_valid, out_ok;
   logic signed [DW-1:0]  win_x, win_y, win_z;

   // global advance: the output register is free or being drained
   assign en         = !out_valid || rsp_tready;
   assign req_tready = en;
   assign req_acc    = req_tvalid && en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_x_ff <= '0;
         vp_y_ff <= '0;
         vp_w_ff <= '0;
         vp_h_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_VP_X: vp_x_ff <= csr_wdata;
            CSR_VP_Y: vp_y_ff <= csr_wdata;
            CSR_VP_W: vp_w_ff <= csr_wdata[VP_SIZE_W-1:0];
            CSR_VP_H: vp_h_ff <= csr_wdata[VP_SIZE_W-1:0];
         endcase
      end
   end

   // input register
   always_comb begin
      ctl0_in.valid = req_acc;
      ctl0_in.proj  = req_tuser[0];
      ctl0_in.idx   = req_tdata[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (en) begin
         ctl0_ff <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coef0_ff   <= req_tdata[IDX_W +: DW];
         vec0_ff[0] <= req_tdata[IDX_W + DW +: DW];
         vec0_ff[1] <= req_tdata[IDX_W + 2*DW +: DW];
         vec0_ff[2] <= req_tdata[IDX_W + 3*DW +: DW];
         vec0_ff[3] <= ONE_Q;
      end
   end

   // object to eye
   vpw_xform #(
      .DATA_WIDTH (DW),
      .FRAC_BITS  (FRAC_BITS),
      .MAT_SEL    (1'b0)
   ) u_model (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (ctl0_ff),
      .in_coef  (coef0_ff),
      .in_vec   (vec0_ff),
      .out_ctl  (ctl1),
      .out_coef (coef1),
      .out_vec  (eye)
   );

   // eye to clip
   vpw_xform #(
      .DATA_WIDTH (DW),
      .FRAC_BITS  (FRAC_BITS),
      .MAT_SEL    (1'b1)
   ) u_proj (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (ctl1),
      .in_coef  (coef1),
      .in_vec   (eye),
      .out_ctl  (ctl2),
      .out_coef (),
      .out_vec  (clip)
   );

   // w threshold and tag delay alongside the dividers
   always_comb begin
      tag_in.valid = ctl2.valid && (ctl2.proj == REQ_PROJECT);
      tag_in.ok    = (clip[3] >= W_MIN_Q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            tag_ff[i] <= '0;
         end
      end else if (en) begin
         tag_ff[0] <= tag_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   vpw_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock), .en (en), .num (clip[0]), .den (clip[3]), .quo (nx)
   );

   vpw_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock), .en (en), .num (clip[1]), .den (clip[3]), .quo (ny)
   );

   vpw_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_z (
      .clock (clock), .en (en), .num (clip[2]), .den (clip[3]), .quo (nz)
   );

   // viewport mapping and output register
   vpw_window #(
      .DATA_WIDTH (DW),
      .FRAC_BITS  (FRAC_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_tag    (tag_ff[DIV_LAT-1]),
      .nx        (nx),
      .ny        (ny),
      .nz        (nz),
      .vp_x      (vp_x_ff),
      .vp_y      (vp_y_ff),
      .vp_w      (vp_w_ff),
      .vp_h      (vp_h_ff),
      .out_valid (out_valid),
      .out_ok    (out_ok),
      .win_x     (win_x),
      .win_y     (win_y),
      .win_z     (win_z)
   );

   assign rsp_tvalid   = out_valid;
   assign rsp_tdata    = RSP_W'({win_z, win_y, win_x});
   assign rsp_tuser[0] = out_ok;

endmodule
`default_nettype wire

@@ hdl/vpw_checker.sv @@
// Port-level checks of the vertex projection block and their bind.
`default_nettype none
`include "vertex_project_to_window_assert.svh"
module vpw_checker #(
   parameter int DATA_WIDTH = 32,
   localparam int RSP_W = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic [0:0]       rsp_tuser
);
   // a stalled result word stays offered
   `VPW_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result word dropped")
   // a rejected point carries zero coordinates
   `VPW_ASSERT_NOW(a_reject_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0, "rejected word not zero")
   // a draining output never stalls the input side
   `VPW_ASSERT_NOW(a_flow_through, clock, reset, rsp_tready, req_tready, "input stalled while output drains")
   // an empty output register never stalls the input side
   `VPW_ASSERT_NOW(a_idle_ready, clock, reset, !rsp_tvalid, req_tready, "input stalled while output empty")

endmodule

bind vertex_project_to_window vpw_checker #(.DATA_WIDTH(DATA_WIDTH)) u_vpw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
